FILE: hw/rtl/bounded_lifo_stack_with_dump_defines.svh
// assertion macros shared by the stack rtl
`ifndef BOUNDED_LIFO_STACK_WITH_DUMP_DEFINES_SVH
`define BOUNDED_LIFO_STACK_WITH_DUMP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BLS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence checked in the same cycle as the trigger
`define BLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the trigger
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bls_pkg.sv
// shared types and constants of the bounded stack
package bls_pkg;

  // fixed widths of the word fields and the capacity register
  localparam int VAL_W = 32;
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef logic [CAP_W-1:0] cap_t;

  // input command codes
  typedef enum logic [1:0] {
    CMD_PUSH        = 2'd0,
    CMD_POP         = 2'd1,
    CMD_DUMP_TOP    = 2'd2,
    CMD_DUMP_BOTTOM = 2'd3
  } cmd_e;

  // one input word
  typedef struct packed {
    cmd_e                    command;
    logic signed [VAL_W-1:0] push_value;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_word_t;

  // per-cycle move of the cell chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_DOWN,
    OP_SHIFT_UP
  } cell_op_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

FILE: hw/rtl/bls_cell.sv
// one storage cell of the stack chain
module bls_cell (
  input  logic                             clk,
  input  bls_pkg::cell_op_t                op,
  input  logic signed [bls_pkg::VAL_W-1:0] prev_val,
  input  logic signed [bls_pkg::VAL_W-1:0] next_val,
  output logic signed [bls_pkg::VAL_W-1:0] val
);
  import bls_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // take the value from the neighbour nearer the top or nearer the bottom
  always_comb begin
    case (op)
      OP_SHIFT_DOWN: val_nxt = prev_val;
      OP_SHIFT_UP:   val_nxt = next_val;
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: hw/rtl/bounded_lifo_stack_with_dump.sv
// Bounded LIFO stack of signed 32-bit values held in a chain of DEPTH cells, cell 0 being the
// top. A push shifts the chain down by one and a pop shifts it up by one, so both take one
// word per cycle outside a dump. A dump word stalls the input until the dump ends: the whole
// chain is rotated once round, one cell per cycle unless a result is held back, and the stored
// entries are emitted on the way (top first from cell 0, bottom first from the last cell),
// leaving the contents as they were. Output back-pressure stretches a dump by the cycles in
// which a result cannot move on. A dump of an empty stack gives no result. Pushes beyond the
// capacity register (saturated to DEPTH) are dropped; pops on an empty stack are dropped.
`include "bounded_lifo_stack_with_dump_defines.svh"

module bounded_lifo_stack_with_dump #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  bls_pkg::in_word_t  in_data,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output bls_pkg::out_word_t out_data,
  // capacity register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bls_pkg::cap_t      cfg_data
);
  import bls_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t            state_r, state_nxt;
  logic              dump_top_r, dump_top_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  cap_t              cap_r;
  cap_t              eff_cap;
  logic              out_vld_r, out_vld_nxt;
  out_word_t         out_r, out_nxt;

  cell_op_t                chain_op;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic signed [VAL_W-1:0] top_src;

  logic             in_acc;
  logic             full;
  logic             slot_free;
  logic             emit;
  logic             emit_last;
  logic             adv;
  logic [CNT_W-1:0] step_ext;
  logic             last_step;

  // capacity register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  assign eff_cap = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign full    = (CAP_W'(cnt_r) >= eff_cap);

  // input handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // dump step decode
  assign step_ext  = CNT_W'(step_r);
  assign last_step = (step_r == IDX_W'(DEPTH - 1));
  assign slot_free = !out_vld_r || !out_stall;

  always_comb begin
    if (dump_top_r) begin
      emit      = (step_ext < cnt_r);
      emit_last = (step_ext == cnt_r - CNT_W'(1));
    end else begin
      emit      = (step_ext >= CNT_W'(DEPTH) - cnt_r);
      emit_last = last_step;
    end
  end

  assign adv = (state_r == ST_DUMP) && (!emit || slot_free);

  // controller: next state, fill count and chain move
  always_comb begin
    state_nxt    = state_r;
    dump_top_nxt = dump_top_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    chain_op     = OP_HOLD;
    top_src      = cell_val[DEPTH-1];
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_PUSH: begin
              if (!full) begin
                chain_op = OP_SHIFT_DOWN;
                top_src  = in_data.push_value;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (cnt_r != '0) begin
                chain_op = OP_SHIFT_UP;
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            default: begin
              state_nxt    = ST_DUMP;
              dump_top_nxt = (in_data.command == CMD_DUMP_TOP);
              step_nxt     = '0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (adv) begin
          chain_op = dump_top_r ? OP_SHIFT_UP : OP_SHIFT_DOWN;
          step_nxt = step_r + IDX_W'(1);
          if (last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dump_top_r <= 1'b0;
      step_r     <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      dump_top_r <= dump_top_nxt;
      step_r     <= step_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // chain of cells: cell 0 is the top, the ends wrap round for a dump
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_v;
    logic signed [VAL_W-1:0] next_v;
    if (i == 0) begin : g_top
      assign prev_v = top_src;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign next_v = cell_val[0];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end
    bls_cell u_cell (
      .clk      (clk),
      .op       (chain_op),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i])
    );
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (adv && emit) begin
      out_vld_nxt         = 1'b1;
      out_nxt.entry_value = dump_top_r ? cell_val[0] : cell_val[DEPTH-1];
      out_nxt.last        = emit_last;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // checks
  `BLS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(DEPTH), "fill count beyond depth")
  `BLS_ASSERT_NEXT(a_cnt_dump, state_r == ST_DUMP, $stable(cnt_r), "fill count moved in dump")
  `BLS_ASSERT_NEXT(a_dump_end, adv && last_step, state_r == ST_IDLE, "dump did not finish")
  `BLS_ASSERT_IMP(a_emit_slot, adv && emit, slot_free, "result word overwritten")

endmodule
